// File: design/pds_pkg.sv
// Package for the power domain sequencer.
// Holds the phase, command and result codes, the shared structs and the
// hi-word-mask helper. No dependencies.
package pds_pkg;

  // Sequencer phases.
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_WAIT_ON   = 3'd1;
  localparam logic [2:0] PH_ACK_CLEAR = 3'd2;
  localparam logic [2:0] PH_ACK_SET   = 3'd3;
  localparam logic [2:0] PH_IDLE_REQ  = 3'd4;

  // Command codes carried with each input item.
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_POWER_ON  = 2'd1;
  localparam logic [1:0] OP_POWER_OFF = 2'd2;
  localparam logic [1:0] OP_IDLE_REQ  = 2'd3;

  // Completion codes.
  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_NOT_READY = 2'd1;
  localparam logic [1:0] RES_HW_TIMEOUT = 2'd2;
  localparam logic [1:0] RES_IDLE_WARN = 2'd3;

  // Write targets.
  localparam logic TGT_GATE = 1'b0;
  localparam logic TGT_IDLE = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_GATE_MASK    = 3'd0;
  localparam logic [2:0] REG_REPAIR_MASK  = 3'd1;
  localparam logic [2:0] REG_GSTAT_MASK   = 3'd2;
  localparam logic [2:0] REG_REQUEST_MASK = 3'd3;
  localparam logic [2:0] REG_ACK_MASK     = 3'd4;
  localparam logic [2:0] REG_QUIET_MASK   = 3'd5;
  localparam logic [2:0] REG_POLL_LIMIT   = 3'd6;

  localparam logic [15:0] POLL_LIMIT_RESET = 16'd10000;

  typedef struct packed {
    logic [15:0] gate_mask;
    logic [15:0] repair_mask;
    logic [15:0] gstat_mask;
    logic [15:0] request_mask;
    logic [15:0] acknowledge_mask;
    logic [15:0] quiet_mask;
    logic [15:0] poll_limit;
  } pds_cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] poll_count;
    logic        wanted_idle;
  } pds_state_t;

  typedef struct packed {
    logic        busy_res;
    logic [1:0]  result_code;
    logic        done_res;
    logic [31:0] write_word;
    logic        write_target;
    logic        write_valid;
  } pds_result_t;

  // Hi-word-mask write: mask in the upper half, masked value in the lower.
  function automatic logic [31:0] hiword(input logic [15:0] mask, input logic [15:0] value);
    hiword = {mask, value & mask};
  endfunction

endpackage

// File: design/pds_step.sv
// Next-state and result logic for one item of the power domain sequencer.
// Purely combinational; depends on pds_pkg.
module pds_step import pds_pkg::*; (
  input  pds_cfg_t    cfg,
  input  pds_state_t  state,
  input  logic [1:0]  operation,
  input  logic        idle_target,
  input  logic        mmio_ready,
  input  logic [15:0] status_word,
  input  logic [15:0] repair_word,
  input  logic [15:0] ack_word,
  input  logic [15:0] quiet_word,
  output pds_state_t  state_next,
  output pds_result_t result
);

  logic        dom_on;
  logic        ack_any;
  logic        ack_match;
  logic [15:0] count_inc;
  logic [15:0] limit_eff;
  logic        budget_out;

  // Domain-on check: repair bit wins, then gate status, else assumed on.
  always_comb begin
    if (cfg.repair_mask != 16'd0) begin
      dom_on = (repair_word & cfg.repair_mask) != 16'd0;
    end else if (cfg.gstat_mask != 16'd0) begin
      dom_on = (status_word & cfg.gstat_mask) == 16'd0;
    end else begin
      dom_on = 1'b1;
    end
  end

  assign ack_any   = (ack_word & cfg.acknowledge_mask) != 16'd0;
  assign ack_match = (ack_word & cfg.acknowledge_mask) ==
                     (state.wanted_idle ? cfg.acknowledge_mask : 16'd0);

  // Poll budget: a zero limit behaves as one.
  assign count_inc  = state.poll_count + 16'd1;
  assign limit_eff  = (cfg.poll_limit == 16'd0) ? 16'd1 : cfg.poll_limit;
  assign budget_out = count_inc >= limit_eff;

  always_comb begin
    state_next = state;
    result     = '0;

    if (state.phase == PH_IDLE) begin
      // Command start.
      if (operation != OP_TICK) begin
        if (!mmio_ready) begin
          result.done_res    = 1'b1;
          result.result_code = RES_NOT_READY;
        end else if (operation == OP_POWER_ON) begin
          result.write_valid   = 1'b1;
          result.write_target  = TGT_GATE;
          result.write_word    = hiword(cfg.gate_mask, 16'd0);
          state_next.phase      = PH_WAIT_ON;
          state_next.poll_count = 16'd0;
        end else if (operation == OP_POWER_OFF) begin
          result.write_valid = 1'b1;
          if (cfg.request_mask != 16'd0) begin
            result.write_target   = TGT_IDLE;
            result.write_word     = hiword(cfg.request_mask, cfg.request_mask);
            state_next.phase      = PH_ACK_SET;
            state_next.poll_count = 16'd0;
          end else begin
            result.write_target = TGT_GATE;
            result.write_word   = hiword(cfg.gate_mask, cfg.gate_mask);
            result.done_res     = 1'b1;
          end
        end else begin
          if (cfg.request_mask == 16'd0) begin
            result.done_res = 1'b1;
          end else begin
            result.write_valid     = 1'b1;
            result.write_target    = TGT_IDLE;
            result.write_word      = hiword(cfg.request_mask,
                                            idle_target ? cfg.request_mask : 16'd0);
            state_next.wanted_idle = idle_target;
            state_next.phase       = PH_IDLE_REQ;
            state_next.poll_count  = 16'd0;
          end
        end
      end
    end else if (operation == OP_TICK) begin
      // One poll of the sampled status words.
      case (state.phase)
        PH_WAIT_ON: begin
          if (dom_on) begin
            if (cfg.request_mask == 16'd0 || (quiet_word & cfg.quiet_mask) == 16'd0) begin
              result.done_res  = 1'b1;
              state_next.phase = PH_IDLE;
            end else begin
              result.write_valid    = 1'b1;
              result.write_target   = TGT_IDLE;
              result.write_word     = hiword(cfg.request_mask, 16'd0);
              state_next.phase      = PH_ACK_CLEAR;
              state_next.poll_count = 16'd0;
            end
          end else begin
            state_next.poll_count = count_inc;
            if (budget_out) begin
              result.done_res    = 1'b1;
              result.result_code = RES_HW_TIMEOUT;
              state_next.phase   = PH_IDLE;
            end
          end
        end
        PH_ACK_CLEAR: begin
          if (!ack_any) begin
            result.done_res  = 1'b1;
            state_next.phase = PH_IDLE;
          end else begin
            state_next.poll_count = count_inc;
            if (budget_out) begin
              result.done_res    = 1'b1;
              result.result_code = RES_HW_TIMEOUT;
              state_next.phase   = PH_IDLE;
            end
          end
        end
        PH_ACK_SET: begin
          if (ack_any) begin
            result.write_valid  = 1'b1;
            result.write_target = TGT_GATE;
            result.write_word   = hiword(cfg.gate_mask, cfg.gate_mask);
            result.done_res     = 1'b1;
            state_next.phase    = PH_IDLE;
          end else begin
            state_next.poll_count = count_inc;
            if (budget_out) begin
              result.done_res    = 1'b1;
              result.result_code = RES_HW_TIMEOUT;
              state_next.phase   = PH_IDLE;
            end
          end
        end
        PH_IDLE_REQ: begin
          if (ack_match) begin
            result.done_res  = 1'b1;
            state_next.phase = PH_IDLE;
          end else begin
            state_next.poll_count = count_inc;
            if (budget_out) begin
              result.done_res    = 1'b1;
              result.result_code = RES_IDLE_WARN;
              state_next.phase   = PH_IDLE;
            end
          end
        end
        default: begin
          state_next.phase = PH_IDLE;
        end
      endcase
    end

    result.busy_res = state_next.phase != PH_IDLE;
  end

endmodule

// File: design/power_domain_sequencer.sv
// Top level of the power domain sequencer: stream ports, configuration
// registers, sequencer state and the result register.
// Depends on pds_pkg and pds_step.
//
// Usage: each input transfer on the s_ side is a command (power on, power
// off, idle request) or a tick that carries one sample of the status, repair,
// acknowledge and bus-idle words; every tick while busy counts as one poll.
// Each input transfer yields exactly one result transfer on the m_ side,
// telling whether a register write is issued (hi-word-mask word), whether the
// command is done with which code, and whether the sequencer is still busy.
// The result appears in the cycle after the input transfer. Throughput is
// one item per cycle unless the receiver stalls; the only stored element on
// the path is the result register, and the sequencer state updates with it.
// When the receiver stalls, the result register holds its item and s_tready
// falls only while that register is full and not being taken.
// The user must write the configuration registers through cfg_wr_en/cfg_addr/
// cfg_wdata only while no item is in flight; the block does not enforce it.
// Reset clears the state to idle, empties the result register and loads the
// register defaults (all masks zero, poll limit 10000).
module power_domain_sequencer import pds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // idle_target[0], mmio_ready[1], status_word[17:2], repair_word[33:18],
  // ack_word[49:34], quiet_word[65:50], zero fill[71:66]
  input  logic [71:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]  s_tuser,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // write_valid[0], write_target[1], write_word[33:2], done_res[34],
  // result_code[36:35], busy_res[37], zero fill[39:38]
  output logic [39:0] m_tdata
);

  pds_cfg_t    cfg;
  pds_state_t  state;
  pds_state_t  state_next;
  pds_result_t step_res;
  pds_result_t res;
  logic        in_xfer;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      // All masks clear; the poll limit sits in the lowest field.
      cfg <= pds_cfg_t'({96'd0, POLL_LIMIT_RESET});
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_GATE_MASK:    cfg.gate_mask        <= cfg_wdata;
        REG_REPAIR_MASK:  cfg.repair_mask      <= cfg_wdata;
        REG_GSTAT_MASK:   cfg.gstat_mask       <= cfg_wdata;
        REG_REQUEST_MASK: cfg.request_mask     <= cfg_wdata;
        REG_ACK_MASK:     cfg.acknowledge_mask <= cfg_wdata;
        REG_QUIET_MASK:   cfg.quiet_mask       <= cfg_wdata;
        REG_POLL_LIMIT:   cfg.poll_limit       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accept when the result register is empty or being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  pds_step u_step (
    .cfg         (cfg),
    .state       (state),
    .operation   (s_tuser),
    .idle_target (s_tdata[0]),
    .mmio_ready  (s_tdata[1]),
    .status_word (s_tdata[17:2]),
    .repair_word (s_tdata[33:18]),
    .ack_word    (s_tdata[49:34]),
    .quiet_word  (s_tdata[65:50]),
    .state_next  (state_next),
    .result      (step_res)
  );

  // Sequencer state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res <= step_res;
    end
  end

  assign m_tdata = {2'b00, res};

  // A finished command never reports busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.done_res && res.busy_res))
    else $error("done and busy reported together");

  // A nonzero completion code only comes with done.
  a_code_needs_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.result_code != RES_OK) |-> res.done_res)
    else $error("result code without done");

  // Without a write the write fields are zero.
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res.write_valid) |-> (res.write_word == 32'd0 && !res.write_target))
    else $error("write fields set without write");

  // Busy on a result means the sequencer is out of idle.
  a_busy_phase: assert property (@(posedge clk) disable iff (rst)
    (in_xfer) |=> (res.busy_res == (state.phase != PH_IDLE)))
    else $error("busy flag disagrees with phase");

endmodule

// File: sim/power_domain_sequencer_test.sv
// Testbench for the power domain sequencer: drives commands and status ticks
// over the input stream and checks every result against a cycle-free predictor.
// Depends on pds_pkg and the power_domain_sequencer RTL.
`timescale 1ns / 100ps

// Predicts the result of each accepted item and checks the results in order.
class domain_result_board;
  logic [15:0] gate_mask, repair_mask, gstat_mask, request_mask;
  logic [15:0] ack_mask, quiet_mask, poll_limit;
  logic [2:0]  phase;
  logic [15:0] poll_count;
  logic        wanted_idle;
  pds_pkg::pds_result_t pending_results[$];
  int mismatches;

  function new();
    gate_mask = '0;
    repair_mask = '0;
    gstat_mask = '0;
    request_mask = '0;
    ack_mask = '0;
    quiet_mask = '0;
    poll_limit = pds_pkg::POLL_LIMIT_RESET;
    phase = pds_pkg::PH_IDLE;
    poll_count = '0;
    wanted_idle = 1'b0;
    mismatches = 0;
  endfunction

  function void set_register(logic [2:0] index, logic [15:0] value);
    case (index)
      pds_pkg::REG_GATE_MASK:    gate_mask = value;
      pds_pkg::REG_REPAIR_MASK:  repair_mask = value;
      pds_pkg::REG_GSTAT_MASK:   gstat_mask = value;
      pds_pkg::REG_REQUEST_MASK: request_mask = value;
      pds_pkg::REG_ACK_MASK:     ack_mask = value;
      pds_pkg::REG_QUIET_MASK:   quiet_mask = value;
      pds_pkg::REG_POLL_LIMIT:   poll_limit = value;
      default: ;
    endcase
  endfunction

  // One failed poll; true once the budget is used up. A limit of zero acts as one.
  function bit poll_exhausted();
    logic [15:0] budget;
    budget = (poll_limit == 16'd0) ? 16'd1 : poll_limit;
    poll_count = poll_count + 16'd1;
    return poll_count >= budget;
  endfunction

  function int outstanding();
    return pending_results.size();
  endfunction

  // Works out the result of one accepted item and queues it.
  function void note_item(logic [1:0] op, logic idle_target, logic ready,
                          logic [15:0] status_word, logic [15:0] repair_word,
                          logic [15:0] ack_word, logic [15:0] quiet_word);
    pds_pkg::pds_result_t r;
    logic on;
    logic [15:0] ack_goal;
    r = '0;
    if (phase == pds_pkg::PH_IDLE) begin
      if (op != pds_pkg::OP_TICK) begin
        if (!ready) begin
          r.done_res = 1'b1;
          r.result_code = pds_pkg::RES_NOT_READY;
        end else if (op == pds_pkg::OP_POWER_ON) begin
          r.write_valid = 1'b1;
          r.write_target = pds_pkg::TGT_GATE;
          r.write_word = {gate_mask, 16'h0000};
          phase = pds_pkg::PH_WAIT_ON;
          poll_count = '0;
        end else if (op == pds_pkg::OP_POWER_OFF) begin
          r.write_valid = 1'b1;
          if (request_mask != 16'd0) begin
            r.write_target = pds_pkg::TGT_IDLE;
            r.write_word = {request_mask, request_mask};
            phase = pds_pkg::PH_ACK_SET;
            poll_count = '0;
          end else begin
            // No idle handshake: the gate bit goes up at once.
            r.write_target = pds_pkg::TGT_GATE;
            r.write_word = {gate_mask, gate_mask};
            r.done_res = 1'b1;
          end
        end else if (request_mask == 16'd0) begin
          r.done_res = 1'b1;
        end else begin
          r.write_valid = 1'b1;
          r.write_target = pds_pkg::TGT_IDLE;
          r.write_word = {request_mask, idle_target ? request_mask : 16'h0000};
          wanted_idle = idle_target;
          phase = pds_pkg::PH_IDLE_REQ;
          poll_count = '0;
        end
      end
    end else if (op == pds_pkg::OP_TICK) begin
      case (phase)
        pds_pkg::PH_WAIT_ON: begin
          if (repair_mask != 16'd0) on = (repair_word & repair_mask) != 16'd0;
          else if (gstat_mask != 16'd0) on = (status_word & gstat_mask) == 16'd0;
          else on = 1'b1;
          if (on) begin
            if (request_mask == 16'd0 || (quiet_word & quiet_mask) == 16'd0) begin
              r.done_res = 1'b1;
              phase = pds_pkg::PH_IDLE;
            end else begin
              // Bus reads idle: drop the idle request and wait for the ack to clear.
              r.write_valid = 1'b1;
              r.write_target = pds_pkg::TGT_IDLE;
              r.write_word = {request_mask, 16'h0000};
              phase = pds_pkg::PH_ACK_CLEAR;
              poll_count = '0;
            end
          end else if (poll_exhausted()) begin
            r.done_res = 1'b1;
            r.result_code = pds_pkg::RES_HW_TIMEOUT;
            phase = pds_pkg::PH_IDLE;
          end
        end
        pds_pkg::PH_ACK_CLEAR: begin
          if ((ack_word & ack_mask) == 16'd0) begin
            r.done_res = 1'b1;
            phase = pds_pkg::PH_IDLE;
          end else if (poll_exhausted()) begin
            r.done_res = 1'b1;
            r.result_code = pds_pkg::RES_HW_TIMEOUT;
            phase = pds_pkg::PH_IDLE;
          end
        end
        pds_pkg::PH_ACK_SET: begin
          if ((ack_word & ack_mask) != 16'd0) begin
            r.write_valid = 1'b1;
            r.write_target = pds_pkg::TGT_GATE;
            r.write_word = {gate_mask, gate_mask};
            r.done_res = 1'b1;
            phase = pds_pkg::PH_IDLE;
          end else if (poll_exhausted()) begin
            r.done_res = 1'b1;
            r.result_code = pds_pkg::RES_HW_TIMEOUT;
            phase = pds_pkg::PH_IDLE;
          end
        end
        pds_pkg::PH_IDLE_REQ: begin
          ack_goal = wanted_idle ? ack_mask : 16'h0000;
          if ((ack_word & ack_mask) == ack_goal) begin
            r.done_res = 1'b1;
            phase = pds_pkg::PH_IDLE;
          end else if (poll_exhausted()) begin
            r.done_res = 1'b1;
            r.result_code = pds_pkg::RES_IDLE_WARN;
            phase = pds_pkg::PH_IDLE;
          end
        end
        default: phase = pds_pkg::PH_IDLE;
      endcase
    end
    r.busy_res = (phase != pds_pkg::PH_IDLE);
    pending_results.push_back(r);
  endfunction

  // Compares one accepted result with the oldest prediction.
  function void check_result(logic [39:0] word);
    pds_pkg::pds_result_t got, want;
    got = pds_pkg::pds_result_t'(word[37:0]);
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result %h arrived with no prediction pending", $time, word);
      return;
    end
    want = pending_results.pop_front();
    if (got.write_valid !== want.write_valid || got.write_target !== want.write_target ||
        got.write_word !== want.write_word || got.done_res !== want.done_res ||
        got.result_code !== want.result_code || got.busy_res !== want.busy_res) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result mismatch", $time);
        $display("  expected wv=%0d tgt=%0d word=%h done=%0d code=%0d busy=%0d",
                 want.write_valid, want.write_target, want.write_word,
                 want.done_res, want.result_code, want.busy_res);
        $display("  actual   wv=%0d tgt=%0d word=%h done=%0d code=%0d busy=%0d",
                 got.write_valid, got.write_target, got.write_word,
                 got.done_res, got.result_code, got.busy_res);
      end
    end
  endfunction
endclass

module power_domain_sequencer_test;
  import pds_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int PHASE_COUNT = 7;
  localparam int ITEMS_PER_PHASE = 55;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  // idle_target[0], mmio_ready[1], status_word[17:2], repair_word[33:18],
  // ack_word[49:34], quiet_word[65:50], zero fill[71:66]
  logic [71:0] s_tdata;
  // operation[1:0]
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // write_valid[0], write_target[1], write_word[33:2], done_res[34],
  // result_code[36:35], busy_res[37], zero fill[39:38]
  logic [39:0] m_tdata;

  domain_result_board board;
  int items_sent;
  int idle_cycles;
  bit calm_tail;
  bit hold_off_request;

  power_domain_sequencer uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample words lean on the all-zero and all-one corners.
  function automatic logic [15:0] sample_word();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_mask();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'h0001 << $urandom_range(0, 15);
    endcase
  endfunction

  // Offers one item, waits for its transfer, then maybe idles for a burst.
  task automatic send_item(input logic [1:0] op, input logic idle_target,
                           input logic ready, input logic [15:0] status_word,
                           input logic [15:0] repair_word, input logic [15:0] ack_word,
                           input logic [15:0] quiet_word);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {6'b0, quiet_word, ack_word, repair_word, status_word, ready, idle_target};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(op, idle_target, ready, status_word, repair_word, ack_word, quiet_word);
    items_sent++;
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_tick(input logic [15:0] status_word, input logic [15:0] repair_word,
                           input logic [15:0] ack_word, input logic [15:0] quiet_word);
    send_item(OP_TICK, 1'b0, 1'b1, status_word, repair_word, ack_word, quiet_word);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr <= index;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_register(index, value);
  endtask

  // Loads all seven registers once the sequencer has no item in flight.
  task automatic apply_setting(input logic [15:0] gate, input logic [15:0] repair,
                               input logic [15:0] status, input logic [15:0] request,
                               input logic [15:0] ack, input logic [15:0] quiet,
                               input logic [15:0] limit);
    drain_results();
    write_reg(REG_GATE_MASK, gate);
    write_reg(REG_REPAIR_MASK, repair);
    write_reg(REG_GSTAT_MASK, status);
    write_reg(REG_REQUEST_MASK, request);
    write_reg(REG_ACK_MASK, ack);
    write_reg(REG_QUIET_MASK, quiet);
    write_reg(REG_POLL_LIMIT, limit);
    cfg_wr_en <= 1'b0;
  endtask

  // A command followed by a few polls, with the odd stray command mixed in.
  task automatic run_sequence();
    logic [1:0] op;
    int polls;
    op = 2'($urandom_range(1, 3));
    send_item(op, 1'($urandom), $urandom_range(0, 7) != 0,
              sample_word(), sample_word(), sample_word(), sample_word());
    polls = $urandom_range(1, 7);
    repeat (polls) begin
      if ($urandom_range(0, 9) == 0)
        send_item(2'($urandom), 1'($urandom), 1'($urandom),
                  sample_word(), sample_word(), sample_word(), sample_word());
      else
        send_item(OP_TICK, 1'($urandom), 1'($urandom),
                  sample_word(), sample_word(), sample_word(), sample_word());
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    m_tready <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
        hold_off_request = 1'b0;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main stimulus.
  initial begin
    int start;
    bit pressure_pending;
    board = new();
    items_sent = 0;
    idle_cycles = 0;
    calm_tail = 1'b0;
    hold_off_request = 1'b0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_addr <= REG_GATE_MASK;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= OP_TICK;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: no masks; a ready power-on ends at its first tick, all else at once.
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_POWER_ON, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_POWER_ON, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_item(OP_POWER_OFF, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_IDLE_REQ, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

    // One-bit masks with a poll budget of two.
    apply_setting(16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0008, 16'h0010, 16'd2);
    // Power-on: not on yet, then idle drop, then the ack never clears.
    send_item(OP_POWER_ON, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0010);
    send_tick(16'h0000, 16'h0002, 16'h0000, 16'h0010);
    send_tick(16'h0000, 16'h0000, 16'h0008, 16'h0000);
    send_tick(16'h0000, 16'h0000, 16'h0008, 16'h0000);
    // Power-on with the bus already active.
    send_item(OP_POWER_ON, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'hFFFF, 16'h0002, 16'h0000, 16'h0000);
    // Power-off, a command while busy, then the ack arrives.
    send_item(OP_POWER_OFF, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_IDLE_REQ, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h0000, 16'h0000, 16'h0008, 16'h0000);
    // Idle entry that times out with a warning, then an idle exit.
    send_item(OP_IDLE_REQ, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_IDLE_REQ, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // Power-off whose ack never comes: no gate write.
    send_item(OP_POWER_OFF, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);

    // Random phases, each under its own register setting.
    pressure_pending = 1'b1;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF);
        2: apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                         16'd1);
        4: apply_setting(pick_mask(), 16'h0000, pick_mask(), pick_mask(), pick_mask(),
                         pick_mask(), 16'($urandom_range(1, 8)));
        default: begin
          logic [15:0] request;
          request = pick_mask();
          apply_setting(pick_mask(), pick_mask(), pick_mask(), request,
                        ($urandom_range(0, 3) != 0) ? request : pick_mask(),
                        pick_mask(), 16'($urandom_range(1, 8)));
        end
      endcase
      if (ph == PHASE_COUNT - 1) calm_tail = 1'b1;
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        if (ph == 3 && pressure_pending && items_sent - start >= 20) begin
          hold_off_request = 1'b1;
          pressure_pending = 1'b0;
        end
        run_sequence();
      end
    end

    drain_results();
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/pds_pkg.sv
design/pds_step.sv
design/power_domain_sequencer.sv
sim/power_domain_sequencer_test.sv
